// ===== hw/rtl/dcd_pkg.sv =====
`timescale 1ns / 1ps

package dcd_pkg;

  // command word layout and fixed values
  localparam logic [8:0]  ESC_DELTA    = 9'd511;
  localparam logic [19:0] PERIOD_MIN   = 20'd1024;
  localparam logic [19:0] PERIOD_RESET = 20'd33333;

  // long division: quotient bits produced one per cycle
  localparam int DIV_STEPS = 23;
  localparam int CNT_W     = 5;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_FIX
  } dcd_state_t;

  // controller to datapath
  typedef struct packed {
    logic take;      // absorb the accepted command word
    logic fast_done; // finish with at most one frame crossed
    logic div_init;  // start the long division
    logic div_step;  // one quotient bit
    logic div_done;  // finish from the division result
  } dcd_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic fast; // accumulator within two frame periods
  } dcd_sts_t;

endpackage

// ===== hw/rtl/display_command_decoder.sv =====
`timescale 1ns / 1ps

// Point-display command decoder.
// Input channel: one 32-bit command word per transfer (in_valid / in_stall).
// Result channel: one result per command word (out_valid / out_stall) with the
// decoded point, its time stamp, frames crossed and the time left in the frame.
// Configuration: cfg_valid / cfg_ready write the 20-bit frame period; values
// below 1024 are held as 1024. Write only while no word is in flight.
// When the accumulator crosses at most one frame, the result is loaded from the
// check state; otherwise a restoring divider runs one quotient bit per cycle
// for the 23-bit frame count, and the fix state loads the result.
// One word is worked on at a time; the next is taken only once it is finished.
// The result sits in an output register; the block takes the next word while
// it waits. A stalled result holds, and the block finishes no further word
// until the output register is free, holding in_stall high meanwhile.
// Reset: synchronous, active low; clears the escape flag and time accumulator,
// sets the frame period to 33333 and empties the output register.

module display_command_decoder import dcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_command_word,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_point_valid,
  output logic [9:0]  out_point_x,
  output logic [9:0]  out_point_y,
  output logic [2:0]  out_point_intensity,
  output logic [32:0] out_point_time,
  output logic [22:0] out_frames_crossed,
  output logic [19:0] out_time_remaining,
  output logic        out_escape_pending,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [19:0] cfg_data
);

  dcd_cmd_t cmd;
  dcd_sts_t sts;
  logic     cfg_wr;

  assign cfg_wr = cfg_valid && cfg_ready;

  // sequencer
  dcd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_ready (cfg_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // decode, accumulator and divider
  dcd_datapath u_datapath (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cmd                 (cmd),
    .sts                 (sts),
    .in_command_word     (in_command_word),
    .cfg_wr              (cfg_wr),
    .cfg_data            (cfg_data),
    .out_point_valid     (out_point_valid),
    .out_point_x         (out_point_x),
    .out_point_y         (out_point_y),
    .out_point_intensity (out_point_intensity),
    .out_point_time      (out_point_time),
    .out_frames_crossed  (out_frames_crossed),
    .out_time_remaining  (out_time_remaining),
    .out_escape_pending  (out_escape_pending)
  );

endmodule

// ===== hw/rtl/dcd_ctrl.sv =====
`timescale 1ns / 1ps

module dcd_ctrl import dcd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  output logic     cfg_ready,
  input  dcd_sts_t sts,
  output dcd_cmd_t cmd
);

  dcd_state_t       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_free;
  logic             cnt_last;

  assign out_free = !out_valid_r || !out_stall;
  assign cnt_last = (cnt_r == CNT_W'(DIV_STEPS - 1));

  // next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_CHECK;
      end
      S_CHECK: begin
        if (!sts.fast) begin
          state_nxt = S_DIV;
          cnt_nxt   = '0;
        end else if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      S_DIV: begin
        cnt_nxt = cnt_r + CNT_W'(1);
        if (cnt_last) state_nxt = S_FIX;
      end
      S_FIX: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs and datapath commands
  always_comb begin
    cmd           = '0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      S_IDLE: begin
        cmd.take = in_valid;
      end
      S_CHECK: begin
        cmd.div_init  = !sts.fast;
        cmd.fast_done = sts.fast && out_free;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
      end
      S_FIX: begin
        cmd.div_done = out_free;
      end
      default: cmd = '0;
    endcase
    if (cmd.fast_done || cmd.div_done) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign cfg_ready = (state_r == S_IDLE);

  // a stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r)
    else $error("result dropped while stalled");

  // an accepted word always goes on to the check state
  a_take_check: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE && in_valid |=> state_r == S_CHECK)
    else $error("accepted word not processed");

  // division counter stays within the quotient width
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> cnt_r < CNT_W'(DIV_STEPS))
    else $error("division counter overrun");

  // a result is never loaded over one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |-> !(cmd.fast_done || cmd.div_done))
    else $error("result overwritten");

endmodule

// ===== hw/rtl/dcd_datapath.sv =====
`timescale 1ns / 1ps

module dcd_datapath import dcd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  dcd_cmd_t    cmd,
  output dcd_sts_t    sts,
  input  logic [31:0] in_command_word,
  input  logic        cfg_wr,
  input  logic [19:0] cfg_data,
  output logic        out_point_valid,
  output logic [9:0]  out_point_x,
  output logic [9:0]  out_point_y,
  output logic [2:0]  out_point_intensity,
  output logic [32:0] out_point_time,
  output logic [22:0] out_frames_crossed,
  output logic [19:0] out_time_remaining,
  output logic        out_escape_pending
);

  // control state
  logic [19:0] period_r, period_nxt;
  logic        esc_r, esc_nxt;
  logic [32:0] acc_r, acc_nxt;

  // staged point fields
  logic        pv_r, pv_nxt;
  logic [9:0]  px_r, px_nxt;
  logic [9:0]  py_r, py_nxt;
  logic [2:0]  pi_r, pi_nxt;
  logic [32:0] pt_r, pt_nxt;

  // divider
  logic [19:0] rem_r, rem_nxt;
  logic [22:0] dvd_r, dvd_nxt;
  logic [22:0] quo_r, quo_nxt;

  // output register
  logic        o_pv_r, o_esc_r;
  logic [9:0]  o_px_r, o_py_r;
  logic [2:0]  o_pi_r;
  logic [32:0] o_pt_r;
  logic [22:0] o_fc_r, o_fc_nxt;
  logic [19:0] o_tr_r, o_tr_nxt;
  logic        o_load;

  logic [8:0]  delta;
  logic [9:0]  word_x, word_y;
  logic [32:0] acc_long, acc_short, acc_m1;
  logic        gt1, gt2;
  logic [32:0] acc_sub;
  logic [20:0] trial;
  logic        trial_ge;
  logic [20:0] rem_inc;

  assign delta  = in_command_word[31:23];
  assign word_x = in_command_word[9:0];
  assign word_y = in_command_word[19:10];

  assign acc_long  = acc_r + {1'b0, in_command_word};
  assign acc_short = acc_r + {24'd0, delta};
  assign acc_m1    = acc_r - 33'd1;

  // frame checks against one and two periods
  assign gt1     = acc_r > {13'd0, period_r};
  assign gt2     = acc_r > {12'd0, period_r, 1'b0};
  assign acc_sub = acc_r - {13'd0, period_r};
  assign sts.fast = !gt2;

  // restoring division step
  assign trial    = {rem_r, dvd_r[22]};
  assign trial_ge = trial >= {1'b0, period_r};
  assign rem_inc  = {1'b0, rem_r} + 21'd1;

  // word decode and accumulator update
  always_comb begin
    esc_nxt    = esc_r;
    acc_nxt    = acc_r;
    pv_nxt     = pv_r;
    px_nxt     = px_r;
    py_nxt     = py_r;
    pi_nxt     = pi_r;
    pt_nxt     = pt_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    o_fc_nxt   = '0;
    o_tr_nxt   = acc_r[19:0];
    o_load     = 1'b0;
    period_nxt = period_r;

    if (cfg_wr) begin
      period_nxt = (cfg_data < PERIOD_MIN) ? PERIOD_MIN : cfg_data;
    end

    if (cmd.take) begin
      pv_nxt = 1'b0;
      px_nxt = '0;
      py_nxt = '0;
      pi_nxt = '0;
      pt_nxt = '0;
      if (esc_r) begin
        esc_nxt = 1'b0;
        acc_nxt = acc_long;
      end else if (delta == ESC_DELTA) begin
        esc_nxt = 1'b1;
      end else begin
        acc_nxt = acc_short;
        if (word_x != '0 || word_y != '0) begin
          pv_nxt = 1'b1;
          px_nxt = word_x;
          py_nxt = word_y;
          pi_nxt = in_command_word[22:20];
          pt_nxt = acc_short;
        end
      end
    end

    // zero or one frame crossed
    if (cmd.fast_done) begin
      o_load = 1'b1;
      if (gt1) begin
        o_fc_nxt = 23'd1;
        acc_nxt  = acc_sub;
      end
    end

    // divide acc - 1 by the period; top bits already below the period
    if (cmd.div_init) begin
      rem_nxt = {10'd0, acc_m1[32:23]};
      dvd_nxt = acc_m1[22:0];
      quo_nxt = '0;
    end

    if (cmd.div_step) begin
      dvd_nxt = {dvd_r[21:0], 1'b0};
      quo_nxt = {quo_r[21:0], trial_ge};
      rem_nxt = trial_ge ? 20'(trial - {1'b0, period_r}) : trial[19:0];
    end

    // remainder of acc - 1, plus one, is what is left
    if (cmd.div_done) begin
      o_load   = 1'b1;
      o_fc_nxt = quo_r;
      acc_nxt  = {12'd0, rem_inc};
    end

    if (o_load) o_tr_nxt = acc_nxt[19:0];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      period_r <= PERIOD_RESET;
      esc_r    <= 1'b0;
      acc_r    <= '0;
    end else begin
      period_r <= period_nxt;
      esc_r    <= esc_nxt;
      acc_r    <= acc_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    pv_r  <= pv_nxt;
    px_r  <= px_nxt;
    py_r  <= py_nxt;
    pi_r  <= pi_nxt;
    pt_r  <= pt_nxt;
    rem_r <= rem_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
    if (o_load) begin
      o_pv_r  <= pv_r;
      o_px_r  <= px_r;
      o_py_r  <= py_r;
      o_pi_r  <= pi_r;
      o_pt_r  <= pt_r;
      o_fc_r  <= o_fc_nxt;
      o_tr_r  <= o_tr_nxt;
      o_esc_r <= esc_r;
    end
  end

  assign out_point_valid     = o_pv_r;
  assign out_point_x         = o_px_r;
  assign out_point_y         = o_py_r;
  assign out_point_intensity = o_pi_r;
  assign out_point_time      = o_pt_r;
  assign out_frames_crossed  = o_fc_r;
  assign out_time_remaining  = o_tr_r;
  assign out_escape_pending  = o_esc_r;

  // stored period never falls below the minimum
  a_period_min: assert property (@(posedge clk) disable iff (!rst_n)
    period_r >= PERIOD_MIN)
    else $error("frame period below minimum");

  // after a finished word the accumulator is within one period
  a_acc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    o_load |=> acc_r <= {13'd0, period_r})
    else $error("accumulator above frame period");

  // division remainder always below the period
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> rem_r < period_r)
    else $error("division remainder out of range");

endmodule
